@@ hw/rtl/bhi_pkg.sv @@
// Shared types and widths for the barycentric height interpolation unit.
`timescale 1ns / 1ps

package bhi_pkg;

    localparam int FRAC_BITS = 16;              // cancels in the quotient; datapath unaffected

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;       // corner differences
    localparam int PROD_W  = 2 * DIFF_W;        // one 33x33 product
    localparam int SUM_W   = PROD_W + 1;        // det, n1, n2
    localparam int SPLIT_W = 34;                // low slice of n1/n2 for the num multiply
    localparam int HIGH_W  = SUM_W - SPLIT_W;   // signed high slice
    localparam int PL_W    = SPLIT_W + 1 + DIFF_W;
    localparam int PH_W    = HIGH_W + DIFF_W;
    localparam int NUM_W   = 100;               // n1*dah + n2*dbh
    localparam int QUO_W   = 34;                // quotient bits kept; larger saturates anyway

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_h;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_h;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_h;
        logic signed [COORD_W-1:0] c_z;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_z;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] height;
        logic                      degenerate;
        logic                      overflow;
    } out_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]   num;
        logic signed [SUM_W-1:0]   det;
        logic signed [COORD_W-1:0] ch;
        logic                      degen;
    } mid_word_t;

endpackage

@@ hw/rtl/bhi_fifo.sv @@
// Small register-based word queue with registered occupancy.
`timescale 1ns / 1ps

module bhi_fifo
    import bhi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

@@ hw/rtl/bhi_front.sv @@
// Front pipeline: differences, products, determinant and numerator.
`timescale 1ns / 1ps

module bhi_front
    import bhi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  in_word_t  in_word,
    output logic      out_valid,
    output mid_word_t out_word
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;

    // stage 1
    logic signed [DIFF_W-1:0] dbz_reg, dcb_reg, dax_reg, daz_reg, dcz_reg;
    logic signed [DIFF_W-1:0] dqx_reg, dqz_reg, dah1_reg, dbh1_reg;
    logic signed [COORD_W-1:0] ch1_reg;
    // stage 2
    logic signed [PROD_W-1:0] p_da_reg, p_db_reg, p_1a_reg, p_1b_reg, p_2a_reg, p_2b_reg;
    logic signed [DIFF_W-1:0] dah2_reg, dbh2_reg;
    logic signed [COORD_W-1:0] ch2_reg;
    // stage 3
    logic signed [SUM_W-1:0]  det3_reg, n1_reg, n2_reg;
    logic signed [DIFF_W-1:0] dah3_reg, dbh3_reg;
    logic signed [COORD_W-1:0] ch3_reg;
    // stage 4
    logic signed [PL_W-1:0]   pl1_reg, pl2_reg;
    logic signed [PH_W-1:0]   ph1_reg, ph2_reg;
    logic signed [SUM_W-1:0]  det4_reg;
    logic                     degen4_reg;
    logic signed [COORD_W-1:0] ch4_reg;
    // stage 5
    mid_word_t                res_reg;

    function automatic logic signed [DIFF_W-1:0] sub33(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        sub33 = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    logic signed [NUM_W-1:0] num_sum;
    assign num_sum = NUM_W'(pl1_reg) + NUM_W'(pl2_reg)
                   + $signed({ph1_reg, {SPLIT_W{1'b0}}})
                   + $signed({ph2_reg, {SPLIT_W{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dbz_reg  <= sub33(in_word.b_z, in_word.c_z);
            dcb_reg  <= sub33(in_word.c_x, in_word.b_x);
            dax_reg  <= sub33(in_word.a_x, in_word.c_x);
            daz_reg  <= sub33(in_word.a_z, in_word.c_z);
            dcz_reg  <= sub33(in_word.c_z, in_word.a_z);
            dqx_reg  <= sub33(in_word.query_x, in_word.c_x);
            dqz_reg  <= sub33(in_word.query_z, in_word.c_z);
            dah1_reg <= sub33(in_word.a_h, in_word.c_h);
            dbh1_reg <= sub33(in_word.b_h, in_word.c_h);
            ch1_reg  <= in_word.c_h;

            p_da_reg <= dbz_reg * dax_reg;
            p_db_reg <= dcb_reg * daz_reg;
            p_1a_reg <= dbz_reg * dqx_reg;
            p_1b_reg <= dcb_reg * dqz_reg;
            p_2a_reg <= dcz_reg * dqx_reg;
            p_2b_reg <= dax_reg * dqz_reg;
            dah2_reg <= dah1_reg;
            dbh2_reg <= dbh1_reg;
            ch2_reg  <= ch1_reg;

            det3_reg <= SUM_W'(p_da_reg) + SUM_W'(p_db_reg);
            n1_reg   <= SUM_W'(p_1a_reg) + SUM_W'(p_1b_reg);
            n2_reg   <= SUM_W'(p_2a_reg) + SUM_W'(p_2b_reg);
            dah3_reg <= dah2_reg;
            dbh3_reg <= dbh2_reg;
            ch3_reg  <= ch2_reg;

            // n = high*2^34 + low, low taken unsigned
            pl1_reg    <= $signed({1'b0, n1_reg[SPLIT_W-1:0]}) * dah3_reg;
            ph1_reg    <= $signed(n1_reg[SUM_W-1:SPLIT_W]) * dah3_reg;
            pl2_reg    <= $signed({1'b0, n2_reg[SPLIT_W-1:0]}) * dbh3_reg;
            ph2_reg    <= $signed(n2_reg[SUM_W-1:SPLIT_W]) * dbh3_reg;
            det4_reg   <= det3_reg;
            degen4_reg <= (det3_reg == '0);
            ch4_reg    <= ch3_reg;

            res_reg.num   <= num_sum;
            res_reg.det   <= det4_reg;
            res_reg.ch    <= ch4_reg;
            res_reg.degen <= degen4_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_word  = res_reg;

endmodule

@@ hw/rtl/bhi_back.sv @@
// Back pipeline: restoring divide one quotient bit per stage, then add and saturate, or zero a degenerate word.
`timescale 1ns / 1ps

module bhi_back
    import bhi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  mid_word_t in_word,
    output logic      out_valid,
    output out_word_t out_word
);

    // abs stage
    logic                      v0_reg;
    logic [NUM_W-1:0]          nabs_reg;
    logic [SUM_W-1:0]          dabs_reg;
    logic                      neg0_reg, degen0_reg;
    logic signed [COORD_W-1:0] ch0_reg;

    // divide stages; index 0 is the range check stage
    logic [QUO_W:0]            vld_reg;
    logic [NUM_W-1:0]          r_reg     [0:QUO_W];
    logic [SUM_W-1:0]          d_reg     [0:QUO_W];
    logic [QUO_W-1:0]          q_reg     [0:QUO_W];
    logic                      neg_reg   [0:QUO_W];
    logic                      big_reg   [0:QUO_W];
    logic                      degen_reg [0:QUO_W];
    logic signed [COORD_W-1:0] ch_reg    [0:QUO_W];

    logic                      fin_vld_reg;
    out_word_t                 fin_reg;

    logic [NUM_W-1:0] num_abs;
    logic [SUM_W-1:0] det_abs;
    assign num_abs = in_word.num[NUM_W-1] ? NUM_W'(-in_word.num) : NUM_W'(in_word.num);
    assign det_abs = in_word.det[SUM_W-1] ? SUM_W'(-in_word.det) : SUM_W'(in_word.det);

    // quotient of 2^34 or more saturates whatever c_h is
    logic big_c;
    assign big_c = {1'b0, nabs_reg} >= ((NUM_W + 1)'(dabs_reg) << QUO_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            vld_reg     <= '0;
            fin_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg      <= in_valid;
            vld_reg     <= {vld_reg[QUO_W-1:0], v0_reg};
            fin_vld_reg <= vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nabs_reg   <= num_abs;
            dabs_reg   <= det_abs;
            neg0_reg   <= in_word.num[NUM_W-1] ^ in_word.det[SUM_W-1];
            degen0_reg <= in_word.degen;
            ch0_reg    <= in_word.ch;

            r_reg[0]     <= nabs_reg;
            d_reg[0]     <= dabs_reg;
            q_reg[0]     <= '0;
            neg_reg[0]   <= neg0_reg;
            big_reg[0]   <= big_c;
            degen_reg[0] <= degen0_reg;
            ch_reg[0]    <= ch0_reg;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        localparam int BIT = QUO_W - 1 - k;
        logic [NUM_W:0] sh;
        logic [NUM_W:0] diff;
        logic           ge;
        assign sh   = {{(NUM_W + 1 - SUM_W){1'b0}}, d_reg[k]} << BIT;
        assign ge   = {1'b0, r_reg[k]} >= sh;
        assign diff = {1'b0, r_reg[k]} - sh;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k+1]      <= ge ? diff[NUM_W-1:0] : r_reg[k];
                q_reg[k+1]      <= q_reg[k] | (QUO_W'(ge) << BIT);
                d_reg[k+1]      <= d_reg[k];
                neg_reg[k+1]    <= neg_reg[k];
                big_reg[k+1]    <= big_reg[k];
                degen_reg[k+1]  <= degen_reg[k];
                ch_reg[k+1]     <= ch_reg[k];
            end
        end
    end

    logic signed [QUO_W+1:0] q_signed;
    logic signed [QUO_W+2:0] h_sum;
    logic                    h_out;
    out_word_t               fin_c;
    assign q_signed = neg_reg[QUO_W] ? -$signed({2'b00, q_reg[QUO_W]})
                                     :  $signed({2'b00, q_reg[QUO_W]});
    assign h_sum    = (QUO_W+3)'(q_signed) + (QUO_W+3)'(ch_reg[QUO_W]);
    assign h_out    = (h_sum[QUO_W+2:COORD_W-1] != '0) && (h_sum[QUO_W+2:COORD_W-1] != '1);

    always_comb
    begin
        fin_c.height     = h_sum[COORD_W-1:0];
        fin_c.degenerate = 1'b0;
        fin_c.overflow   = 1'b0;
        if (degen_reg[QUO_W])
        begin
            fin_c.height     = '0;
            fin_c.degenerate = 1'b1;
        end
        else if (big_reg[QUO_W] || h_out)
        begin
            fin_c.overflow = 1'b1;
            if (big_reg[QUO_W] ? neg_reg[QUO_W] : h_sum[QUO_W+2])
            begin
                fin_c.height = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                fin_c.height = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg <= fin_c;
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_word  = fin_reg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.degenerate) |-> (out_word.height == '0 && !out_word.overflow))
        else $error("degenerate word with nonzero height or overflow");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && out_valid) |=> (out_valid && $stable(out_word)))
        else $error("final stage changed while stalled");
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.overflow) |->
            (out_word.height == {1'b1, {(COORD_W-1){1'b0}}}
             || out_word.height == {1'b0, {(COORD_W-1){1'b1}}}))
        else $error("overflow word not at a saturation limit");
`endif

endmodule

@@ hw/rtl/barycentric_height_interpolate_unit.sv @@
// Path of a word: front pipeline of 5 stages, the first loaded at the accepting edge, then
// the mid queue, the back pipeline and the output queue.
// Throughput: one word per cycle while full is low; the 34-stage divider is fully pipelined.
// Front and back stall independently; a 4-word queue sits between them, a 2-word queue
// at the output. full depends only on registered queue occupancy.
// Reset (rst_n, asynchronous, active low) clears valid bits and queue pointers; no
// clearing pass, accepts a word on the first cycle after reset.
`timescale 1ns / 1ps

module barycentric_height_interpolate_unit
    import bhi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic      front_adv, front_vld;
    mid_word_t front_word;
    logic      mid_full, mid_empty, mid_pop;
    mid_word_t mid_word;
    logic      back_adv, back_vld;
    out_word_t back_word;
    logic      out_full;

    assign front_adv = !mid_full;
    assign full      = !front_adv;
    assign back_adv  = !out_full;
    assign mid_pop   = back_adv && !mid_empty;

    bhi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (front_adv),
        .in_valid  (push),
        .in_word   (item),
        .out_valid (front_vld),
        .out_word  (front_word)
    );

    bhi_fifo #(
        .WIDTH ($bits(mid_word_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_adv && front_vld),
        .wdata (front_word),
        .pop   (mid_pop),
        .rdata (mid_word),
        .full  (mid_full),
        .empty (mid_empty)
    );

    bhi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (back_adv),
        .in_valid  (!mid_empty),
        .in_word   (mid_word),
        .out_valid (back_vld),
        .out_word  (back_word)
    );

    bhi_fifo #(
        .WIDTH ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_adv && back_vld),
        .wdata (back_word),
        .pop   (pop && !empty),
        .rdata (result),
        .full  (out_full),
        .empty (empty)
    );

endmodule

@@ tb/barycentric_height_interpolate_unit_test.sv @@
// Self-checking testbench for the barycentric height interpolation unit.
`timescale 1ns / 1ps

module barycentric_height_interpolate_unit_test;
    import bhi_pkg::*;

    localparam int LATENCY     = 43;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    in_word_t  item = '0;
    out_word_t result;

    in_word_t  pending_words[$];
    out_word_t expected_heights[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        stimulus_done = 1'b0;
    bit        accepted_last = 1'b0;
    int        push_gap = 0;
    int        pop_gap = 0;

    barycentric_height_interpolate_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    // Exact plane interpolation; 128-bit signed covers every intermediate.
    function automatic out_word_t interpolate_height(in_word_t w);
        logic signed [127:0] dbz, dcb, dax, daz, dcz, dqx, dqz, dah, dbh;
        logic signed [127:0] det, n1, n2, num, quo, h;
        out_word_t r;
        dbz = 128'(w.b_z) - 128'(w.c_z);
        dcb = 128'(w.c_x) - 128'(w.b_x);
        dax = 128'(w.a_x) - 128'(w.c_x);
        daz = 128'(w.a_z) - 128'(w.c_z);
        dcz = 128'(w.c_z) - 128'(w.a_z);
        dqx = 128'(w.query_x) - 128'(w.c_x);
        dqz = 128'(w.query_z) - 128'(w.c_z);
        dah = 128'(w.a_h) - 128'(w.c_h);
        dbh = 128'(w.b_h) - 128'(w.c_h);
        det = dbz * dax + dcb * daz;
        n1  = dbz * dqx + dcb * dqz;
        n2  = dcz * dqx + dax * dqz;
        r = '0;
        if (det == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        num = n1 * dah + n2 * dbh;
        quo = num / det;      // SV signed division truncates toward zero
        h = quo + 128'(w.c_h);
        if (h > 128'sd2147483647)
        begin
            r.height = 32'h7FFF_FFFF;
            r.overflow = 1'b1;
        end
        else if (h < -128'sd2147483648)
        begin
            r.height = 32'h8000_0000;
            r.overflow = 1'b1;
        end
        else
            r.height = h[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random triangle; mix of full-range, small-range and edge values.
    function automatic in_word_t random_word();
        in_word_t w;
        logic [31:0] v[11];
        int mode;
        mode = $urandom_range(0, 9);
        foreach (v[i])
        begin
            if (mode < 4)
                v[i] = $urandom;
            else if (mode < 8)
                v[i] = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            else
                v[i] = edge_val();
        end
        w = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10]};
        // occasionally collapse the triangle onto a line
        if ($urandom_range(0, 19) == 0)
        begin
            w.b_x = w.a_x;
            w.b_z = w.a_z;
        end
        return w;
    endfunction

    function automatic in_word_t make_word(logic [31:0] ax, ah, az, bx, bh, bz,
                                           cx, ch, cz, qx, qz);
        return {ax, ah, az, bx, bh, bz, cx, ch, cz, qx, qz};
    endfunction

    initial
    begin
        logic [31:0] ev;
        // unit right triangle, heights 1/2/3, query inside the triangle and at corner a
        pending_words.push_back(make_word(32'h10000, 32'h10000, 0, 0, 32'h20000, 32'h10000,
                                          0, 32'h30000, 0, 32'h4000, 32'h4000));
        pending_words.push_back(make_word(32'h10000, 32'h10000, 0, 0, 32'h20000, 32'h10000,
                                          0, 32'h30000, 0, 32'h10000, 0));
        // point outside the triangle: extrapolated plane
        pending_words.push_back(make_word(32'h10000, 32'hFFFF0000, 0, 0, 32'h20000,
                                          32'h10000, 0, 0, 0, 32'hFFFB0000, 32'h70000));
        // degenerate: all corners equal, and collinear corners
        pending_words.push_back('0);
        pending_words.push_back(make_word(0, 5, 0, 32'h10000, 7, 32'h10000,
                                          32'h20000, 9, 32'h20000, 3, 4));
        pending_words.push_back({11{32'h8000_0000}});
        pending_words.push_back({11{32'h7FFF_FFFF}});
        pending_words.push_back({11{32'hFFFF_FFFF}});
        // extreme spread: overflow low, flat extreme heights, negative det
        pending_words.push_back(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                          32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_words.push_back(make_word(1, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1,
                                          0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(1, 32'h8000_0000, 0, 0, 32'h8000_0000, 1,
                                          0, 32'h8000_0000, 0, 32'h7FFF_FFFF,
                                          32'h7FFF_FFFF));
        pending_words.push_back(make_word(0, 32'h8000_0000, 1, 1, 32'h7FFF_FFFF, 0,
                                          0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        // truncation toward zero, with a negative and a positive quotient
        pending_words.push_back(make_word(3, 0, 0, 0, 0, 3, 0, 1, 0, 1, 0));
        pending_words.push_back(make_word(3, 0, 0, 0, 0, 3, 0, 32'hFFFFFFFF, 0, 1, 0));
        for (int i = 0; i < 12; i++)
        begin
            ev = edge_val();
            pending_words.push_back({11{ev}});
        end
        for (int i = 0; i < N_RANDOM; i++)
            pending_words.push_back(random_word());
        repeat (9) @(posedge clk);
        rst_n = 1'b1;
    end

    // driver: changes inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || accepted_last)
            begin
                if (push_gap > 0)
                begin
                    push <= 1'b0;
                    push_gap <= push_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    item <= pending_words.pop_front();
                    push <= 1'b1;
                    push_gap <= pick_gap();
                end
                else
                begin
                    push <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    pop_gap <= pick_gap();
            end
        end
    end

    // monitor: samples at the rising edge
    always @(posedge clk)
    begin
        out_word_t want;
        cycle_count <= cycle_count + 1;
        accepted_last <= push && !full;
        if (rst_n && push && !full)
            expected_heights.push_back(interpolate_height(item));
        if (rst_n && pop && !empty)
        begin
            if (expected_heights.size() == 0)
            begin
                report_mismatch("unexpected word", result.height, 32'h0);
            end
            else
            begin
                want = expected_heights.pop_front();
                if (result.height !== want.height)
                    report_mismatch("height", result.height, want.height);
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", 32'(result.degenerate),
                                    32'(want.degenerate));
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
            end
        end
    end

    initial
    begin
        wait (stimulus_done && expected_heights.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_heights.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout");
        $display("Verification failed");
        $finish;
    end

endmodule
